>>> rtl/core/rdhuff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rdhuff_pkg;

  localparam int MAX_SYMBOLS     = 512;
  localparam int MAX_CODE_LENGTH = 31;
  localparam int SYM_BITS        = 9;
  localparam int LEN_BITS        = 5;
  localparam int DIM_BITS        = 16;
  localparam int IDX_BITS        = $clog2(MAX_SYMBOLS);
  localparam int CNT_BITS        = 10;
  localparam int CODE_BITS       = 31;
  localparam int NUM_LENGTHS     = 32;

  typedef enum logic [1:0] {
    PH_COUNT,
    PH_ENTRY,
    PH_DECODE,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_PIXEL,
    ST_ENTRY,
    ST_NOMATCH
  } status_t;

  typedef enum logic [1:0] {
    REG_WIDTH,
    REG_HEIGHT
  } reg_index_t;

  typedef struct packed {
    logic code_bit;
    logic frame_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       image_end;
    logic [1:0] status;
  } out_word_t;

  // one decoded result leaving the table stage
  typedef struct packed {
    logic                valid;
    logic                clear;
    status_t             status;
    logic                row_end;
    logic                image_end;
    logic                first_col;
    logic [IDX_BITS-1:0] idx;
  } res_t;

  typedef struct packed {
    logic                en;
    logic [IDX_BITS-1:0] addr;
    logic [SYM_BITS-1:0] data;
  } sym_wr_t;

endpackage

`default_nettype wire

>>> rtl/core/row_delta_canonical_huffman_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | dir | handshake            | word
// in      | in  | in_valid / in_stall  | in_word: code_bit, frame_start
// out     | out | out_valid / out_stall| out_word: pixel, row_end, image_end, status
// cfg     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data (width, height)
//
// one coded bit is taken every cycle unless in_stall is high; a result leaves through the registered
// read of the symbol memory and the pixel register after it.
// rst is synchronous and clears control state and the per-length counts.
// in_stall follows out_stall while the output register holds a word.
// cfg_ready is always high.

module row_delta_canonical_huffman_decoder (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire rdhuff_pkg::in_word_t  in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output rdhuff_pkg::out_word_t      out_word,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [rdhuff_pkg::DIM_BITS-1:0] cfg_data
);

  logic [rdhuff_pkg::DIM_BITS-1:0] image_width, image_height;
  logic                acc, adv;
  rdhuff_pkg::res_t    res;
  rdhuff_pkg::sym_wr_t sym_wr;

  assign cfg_ready = 1'b1;
  assign in_stall  = !adv;
  assign acc       = in_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= rdhuff_pkg::DIM_BITS'(1);
      image_height <= rdhuff_pkg::DIM_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rdhuff_pkg::REG_WIDTH) begin
        image_width <= cfg_data;
      end else if (cfg_index == rdhuff_pkg::REG_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  rdhuff_table u_table (
    .clk          (clk),
    .rst          (rst),
    .acc          (acc),
    .in_word      (in_word),
    .image_width  (image_width),
    .image_height (image_height),
    .res          (res),
    .sym_wr       (sym_wr)
  );

  rdhuff_pixel u_pixel (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .sym_wr    (sym_wr),
    .out_stall (out_stall),
    .adv       (adv),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

>>> rtl/core/rdhuff_table.sv
`timescale 1ns / 1ps
`default_nettype none

module rdhuff_table (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         acc,
  input  wire rdhuff_pkg::in_word_t         in_word,
  input  wire logic [rdhuff_pkg::DIM_BITS-1:0] image_width,
  input  wire logic [rdhuff_pkg::DIM_BITS-1:0] image_height,
  output rdhuff_pkg::res_t                  res,
  output rdhuff_pkg::sym_wr_t               sym_wr
);

  localparam int IB = rdhuff_pkg::IDX_BITS;
  localparam int CB = rdhuff_pkg::CODE_BITS;
  localparam int NB = rdhuff_pkg::CNT_BITS;
  localparam int LB = rdhuff_pkg::LEN_BITS;
  localparam int DB = rdhuff_pkg::DIM_BITS;

  rdhuff_pkg::phase_t phase, phase_next, ph_e;
  logic [8:0]    fsh, fsh_next;
  logic [3:0]    fbits, fbits_next;
  logic [8:0]    etotal, eloaded;
  logic [IB:0]   acount;
  logic [8:0]    pend;
  logic [NB-1:0] cnt   [rdhuff_pkg::NUM_LENGTHS];
  logic [CB-1:0] first [rdhuff_pkg::NUM_LENGTHS];
  logic [IB-1:0] base  [rdhuff_pkg::NUM_LENGTHS];
  logic [31:0]   ccode;
  logic [LB-1:0] clen;
  logic [CB-1:0] cshift;
  logic [LB-1:0] clength;
  logic [DB-1:0] col, row;
  logic [14:0]   lkey;

  logic          fs, bit_in;
  logic [8:0]    fsh_e, fsh_sh;
  logic [3:0]    fb_e, fb_inc;
  logic [LB-1:0] len;
  logic [13:0]   key;
  logic          ent_ok, take;
  logic [8:0]    eloaded_inc;
  logic [31:0]   ccode_sh;
  logic [CB-1:0] cs_n, off;
  logic [LB-1:0] cl_n;
  logic [NB-1:0] dc;
  logic          hit, miss_end, idx_bad;
  logic [IB:0]   sidx;
  logic [DB-1:0] w_eff, h_eff, col_inc, row_inc;
  logic          row_done, img_done;

  assign fs     = in_word.frame_start;
  assign bit_in = in_word.code_bit;
  assign ph_e   = fs ? rdhuff_pkg::PH_COUNT : phase;
  assign fsh_e  = fs ? 9'd0 : fsh;
  assign fb_e   = fs ? 4'd0 : fbits;
  assign fsh_sh = {fsh_e[7:0], bit_in};
  assign fb_inc = fb_e + 4'd1;

  // entry check and canonical code step
  assign len   = fsh_sh[LB-1:0];
  assign key   = {len, ~pend[8], pend[7:0]};
  assign ent_ok = (len != '0) && (acount < (IB+1)'(rdhuff_pkg::MAX_SYMBOLS))
                  && (!lkey[14] || key > lkey[13:0]);
  assign take  = (ph_e == rdhuff_pkg::PH_ENTRY) && (fb_inc == 4'd14);
  assign eloaded_inc = eloaded + 9'd1;
  assign ccode_sh = (len > clen) ? (ccode << (len - clen)) : ccode;

  // decode match on length and code
  assign cs_n    = {cshift[CB-2:0], bit_in};
  assign cl_n    = clength + 1'b1;
  assign dc      = cnt[cl_n];
  assign off     = cs_n - first[cl_n];
  assign hit     = (dc != '0) && (off < CB'(dc));
  assign sidx    = {1'b0, base[cl_n]} + (IB+1)'(off[NB-1:0]);
  assign idx_bad = sidx >= (IB+1)'(rdhuff_pkg::MAX_SYMBOLS);
  assign miss_end = (cl_n >= LB'(rdhuff_pkg::MAX_CODE_LENGTH)) || (cl_n == '0);

  assign w_eff    = (image_width == '0) ? DB'(1) : image_width;
  assign h_eff    = (image_height == '0) ? DB'(1) : image_height;
  assign col_inc  = col + 1'b1;
  assign row_inc  = row + 1'b1;
  assign row_done = col_inc >= w_eff;
  assign img_done = row_done && (row_inc >= h_eff);

  always_comb begin
    phase_next = ph_e;
    unique case (ph_e)
      rdhuff_pkg::PH_COUNT: begin
        if (fb_inc >= 4'd9) begin
          phase_next = (fsh_sh != '0) ? rdhuff_pkg::PH_ENTRY : rdhuff_pkg::PH_DECODE;
        end
      end
      rdhuff_pkg::PH_ENTRY: begin
        if (take && eloaded_inc >= etotal) begin
          phase_next = rdhuff_pkg::PH_DECODE;
        end
      end
      rdhuff_pkg::PH_DECODE: begin
        if (hit && !idx_bad && img_done) begin
          phase_next = rdhuff_pkg::PH_DONE;
        end
      end
      default: phase_next = ph_e;
    endcase
  end

  // header field shifter
  always_comb begin
    fsh_next   = fsh_e;
    fbits_next = fb_e;
    unique case (ph_e)
      rdhuff_pkg::PH_COUNT: begin
        if (fb_inc >= 4'd9) begin
          fsh_next   = '0;
          fbits_next = '0;
        end else begin
          fsh_next   = fsh_sh;
          fbits_next = fb_inc;
        end
      end
      rdhuff_pkg::PH_ENTRY: begin
        if (take) begin
          fsh_next   = '0;
          fbits_next = '0;
        end else if (fb_inc == 4'd9) begin
          fsh_next   = '0;
          fbits_next = fb_inc;
        end else begin
          fsh_next   = fsh_sh;
          fbits_next = fb_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res           = '0;
    res.clear     = acc && fs;
    res.status    = rdhuff_pkg::ST_PIXEL;
    res.idx       = sidx[IB-1:0];
    sym_wr.en     = 1'b0;
    sym_wr.addr   = acount[IB-1:0];
    sym_wr.data   = pend;
    unique case (ph_e)
      rdhuff_pkg::PH_ENTRY: begin
        if (take) begin
          res.valid  = acc && !ent_ok;
          res.status = rdhuff_pkg::ST_ENTRY;
          sym_wr.en  = acc && ent_ok;
        end
      end
      rdhuff_pkg::PH_DECODE: begin
        if (hit) begin
          res.valid = acc;
          if (idx_bad) begin
            res.status = rdhuff_pkg::ST_NOMATCH;
          end else begin
            res.row_end   = row_done;
            res.image_end = img_done;
            res.first_col = (col == '0);
          end
        end else if (miss_end) begin
          res.valid  = acc;
          res.status = rdhuff_pkg::ST_NOMATCH;
        end
      end
      default: res.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= rdhuff_pkg::PH_COUNT;
      fsh     <= '0;
      fbits   <= '0;
      etotal  <= '0;
      eloaded <= '0;
      acount  <= '0;
      pend    <= '0;
      ccode   <= '0;
      clen    <= '0;
      cshift  <= '0;
      clength <= '0;
      col     <= '0;
      row     <= '0;
      lkey    <= '0;
      for (int i = 0; i < rdhuff_pkg::NUM_LENGTHS; i++) begin
        cnt[i] <= '0;
      end
    end else if (acc) begin
      phase <= phase_next;
      fsh   <= fsh_next;
      fbits <= fbits_next;
      if (fs) begin
        etotal  <= '0;
        eloaded <= '0;
        acount  <= '0;
        pend    <= '0;
        ccode   <= '0;
        clen    <= '0;
        cshift  <= '0;
        clength <= '0;
        col     <= '0;
        row     <= '0;
        lkey    <= '0;
        for (int i = 0; i < rdhuff_pkg::NUM_LENGTHS; i++) begin
          cnt[i] <= '0;
        end
      end else begin
        unique case (ph_e)
          rdhuff_pkg::PH_COUNT: begin
            if (fb_inc >= 4'd9) begin
              etotal <= fsh_sh;
            end
          end
          rdhuff_pkg::PH_ENTRY: begin
            if (fb_inc == 4'd9) begin
              pend <= fsh_sh;
            end else if (take) begin
              eloaded <= eloaded_inc;
              if (ent_ok) begin
                lkey   <= {1'b1, key};
                clen   <= len;
                ccode  <= ccode_sh + 32'd1;
                acount <= acount + 1'b1;
                cnt[len] <= cnt[len] + 1'b1;
                if (cnt[len] == '0) begin
                  first[len] <= ccode_sh[CB-1:0];
                  base[len]  <= acount[IB-1:0];
                end
              end
            end
          end
          rdhuff_pkg::PH_DECODE: begin
            if (hit || miss_end) begin
              cshift  <= '0;
              clength <= '0;
            end else begin
              cshift  <= cs_n;
              clength <= cl_n;
            end
            if (hit && !idx_bad) begin
              col <= row_done ? '0 : col_inc;
              if (row_done) begin
                row <= row_inc;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  a_pixel_in_decode: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status == rdhuff_pkg::ST_PIXEL |-> phase == rdhuff_pkg::PH_DECODE && !fs)
    else $error("pixel result outside decode");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    phase == rdhuff_pkg::PH_DONE && !(acc && fs) |=> phase == rdhuff_pkg::PH_DONE)
    else $error("done phase left without frame start");

  a_write_in_entry: assert property (@(posedge clk) disable iff (rst)
    sym_wr.en |-> ph_e == rdhuff_pkg::PH_ENTRY && acount < (IB+1)'(rdhuff_pkg::MAX_SYMBOLS))
    else $error("symbol write outside entry load");

endmodule

`default_nettype wire

>>> rtl/core/rdhuff_pixel.sv
`timescale 1ns / 1ps
`default_nettype none

module rdhuff_pixel (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rdhuff_pkg::res_t     res,
  input  wire rdhuff_pkg::sym_wr_t  sym_wr,
  input  wire logic                 out_stall,
  output logic                      adv,
  output logic                      out_valid,
  output rdhuff_pkg::out_word_t     out_word
);

  logic [rdhuff_pkg::SYM_BITS-1:0] store [rdhuff_pkg::MAX_SYMBOLS];
  logic [rdhuff_pkg::SYM_BITS-1:0] rd;

  logic                s2_valid;
  rdhuff_pkg::status_t s2_status;
  logic                s2_row_end, s2_image_end, s2_first_col;
  logic [7:0] prev, rfp;
  logic [7:0] p, rfp_new;
  logic       is_pix;

  assign adv = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (sym_wr.en) begin
      store[sym_wr.addr] <= sym_wr.data;
    end
    if (adv) begin
      rd <= store[res.idx];
    end
  end

  assign is_pix  = s2_valid && (s2_status == rdhuff_pkg::ST_PIXEL);
  assign p       = prev + rd[7:0];
  assign rfp_new = s2_first_col ? p : rfp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      prev      <= '0;
      rfp       <= '0;
    end else if (adv) begin
      s2_valid  <= res.valid;
      out_valid <= s2_valid;
      // an older word still finishes before the new frame clears
      if (res.clear) begin
        prev <= '0;
        rfp  <= '0;
      end else if (is_pix) begin
        rfp  <= rfp_new;
        prev <= s2_row_end ? rfp_new : p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_status    <= res.status;
      s2_row_end   <= res.row_end;
      s2_image_end <= res.image_end;
      s2_first_col <= res.first_col;
      out_word.pixel     <= is_pix ? p : 8'd0;
      out_word.row_end   <= is_pix && s2_row_end;
      out_word.image_end <= is_pix && s2_image_end;
      out_word.status    <= s2_status;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status != rdhuff_pkg::ST_PIXEL |->
      out_word.pixel == 8'd0 && !out_word.row_end && !out_word.image_end)
    else $error("error word carries pixel data");

  a_img_end_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.image_end |-> out_word.row_end)
    else $error("image end without row end");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> s2_valid == $past(s2_valid))
    else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

>>> tb/row_delta_canonical_huffman_decoder_checker.sv
`timescale 1ns / 1ps

module row_delta_canonical_huffman_decoder_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  rdhuff_pkg::in_word_t            in_word,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  rdhuff_pkg::out_word_t           out_word,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [rdhuff_pkg::DIM_BITS-1:0] cfg_data,
  output int                              errors,
  output int                              waiting,
  output int                              results
);

  logic [rdhuff_pkg::DIM_BITS-1:0] img_width, img_height;

  rdhuff_pkg::phase_t phase;
  logic [8:0]   field_shift;
  int           field_bits;
  logic [8:0]   entry_total, entries_loaded, pend_sym;
  int           accepted;
  logic [8:0]   sym_mem [0:rdhuff_pkg::MAX_SYMBOLS-1];
  logic [9:0]   len_count [0:rdhuff_pkg::NUM_LENGTHS-1];
  logic [30:0]  first_code [0:rdhuff_pkg::NUM_LENGTHS-1];
  logic [8:0]   base_idx [0:rdhuff_pkg::NUM_LENGTHS-1];
  logic [31:0]  canon_code;
  logic [4:0]   canon_len;
  logic [30:0]  code_shift;
  logic [4:0]   code_len;
  logic [7:0]   prev_pix, row_first;
  logic [15:0]  col_cnt, row_cnt;
  logic [14:0]  last_key;

  rdhuff_pkg::out_word_t expected_pixels[$];

  assign waiting = expected_pixels.size();

  task automatic clear_frame();
    phase = rdhuff_pkg::PH_COUNT;
    field_shift = '0; field_bits = 0;
    entry_total = '0; entries_loaded = '0; accepted = 0; pend_sym = '0;
    for (int i = 0; i < rdhuff_pkg::NUM_LENGTHS; i++) begin
      len_count[i] = '0; first_code[i] = '0; base_idx[i] = '0;
    end
    canon_code = '0; canon_len = '0; code_shift = '0; code_len = '0;
    prev_pix = '0; row_first = '0; col_cnt = '0; row_cnt = '0; last_key = '0;
  endtask

  task automatic push_word(logic [7:0] pix, logic re, logic ie, rdhuff_pkg::status_t st);
    rdhuff_pkg::out_word_t w;
    w.pixel = pix; w.row_end = re; w.image_end = ie; w.status = st;
    expected_pixels.insert(expected_pixels.size(), w);
  endtask

  task automatic load_entry();
    logic [4:0]  len;
    logic [13:0] key;
    logic        ok;
    len = field_shift[4:0];
    key = {len, pend_sym ^ 9'h100};
    field_shift = '0; field_bits = 0;
    entries_loaded = entries_loaded + 9'd1;
    if (entries_loaded >= entry_total) phase = rdhuff_pkg::PH_DECODE;
    ok = len != 0 && accepted < rdhuff_pkg::MAX_SYMBOLS &&
         (!last_key[14] || key > last_key[13:0]);
    if (!ok) begin
      push_word(8'd0, 1'b0, 1'b0, rdhuff_pkg::ST_ENTRY);
    end else begin
      last_key = {1'b1, key};
      if (len > canon_len) canon_code = canon_code << (len - canon_len);
      canon_len = len;
      if (len_count[len] == 0) begin
        first_code[len] = canon_code[30:0];
        base_idx[len] = accepted[8:0];
      end
      sym_mem[accepted] = pend_sym;
      accepted++;
      len_count[len] = len_count[len] + 10'd1;
      canon_code = canon_code + 32'd1;
    end
  endtask

  task automatic emit_pixel(logic [8:0] sym);
    logic [7:0]  p;
    logic [15:0] w, h;
    logic        re, ie;
    p = prev_pix + sym[7:0];
    w = img_width == 0 ? 16'd1 : img_width;
    h = img_height == 0 ? 16'd1 : img_height;
    re = 0; ie = 0;
    if (col_cnt == 0) row_first = p;
    prev_pix = p;
    col_cnt = col_cnt + 16'd1;
    if (col_cnt >= w) begin
      re = 1; col_cnt = '0; prev_pix = row_first;
      row_cnt = row_cnt + 16'd1;
      if (row_cnt >= h) begin
        ie = 1; phase = rdhuff_pkg::PH_DONE;
      end
    end
    push_word(p, re, ie, rdhuff_pkg::ST_PIXEL);
  endtask

  task automatic decode_bit(logic b);
    logic [30:0] off;
    logic [31:0] idx;
    code_shift = {code_shift[29:0], b};
    code_len = code_len + 5'd1;
    if (len_count[code_len] != 0) begin
      off = code_shift - first_code[code_len];
      if (off < len_count[code_len]) begin
        idx = base_idx[code_len] + off;
        code_shift = '0; code_len = '0;
        if (idx >= rdhuff_pkg::MAX_SYMBOLS)
          push_word(8'd0, 1'b0, 1'b0, rdhuff_pkg::ST_NOMATCH);
        else emit_pixel(sym_mem[idx[8:0]]);
        return;
      end
    end
    if (code_len >= rdhuff_pkg::MAX_CODE_LENGTH || code_len == 0) begin
      code_shift = '0; code_len = '0;
      push_word(8'd0, 1'b0, 1'b0, rdhuff_pkg::ST_NOMATCH);
    end
  endtask

  task automatic predict(rdhuff_pkg::in_word_t w);
    if (w.frame_start) clear_frame();
    case (phase)
      rdhuff_pkg::PH_COUNT: begin
        field_shift = {field_shift[7:0], w.code_bit};
        field_bits++;
        if (field_bits >= rdhuff_pkg::SYM_BITS) begin
          entry_total = field_shift;
          field_shift = '0; field_bits = 0;
          phase = entry_total != 0 ? rdhuff_pkg::PH_ENTRY : rdhuff_pkg::PH_DECODE;
        end
      end
      rdhuff_pkg::PH_ENTRY: begin
        field_shift = {field_shift[7:0], w.code_bit};
        field_bits++;
        if (field_bits == rdhuff_pkg::SYM_BITS) begin
          pend_sym = field_shift;
          field_shift = '0;
        end else if (field_bits >= rdhuff_pkg::SYM_BITS + rdhuff_pkg::LEN_BITS) begin
          load_entry();
        end
      end
      rdhuff_pkg::PH_DECODE: decode_bit(w.code_bit);
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    rdhuff_pkg::out_word_t e;
    if (rst) begin
      img_width <= 16'd1;
      img_height <= 16'd1;
      clear_frame();
      expected_pixels.delete();
      errors <= 0;
      results <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rdhuff_pkg::REG_WIDTH) img_width <= cfg_data;
        else if (cfg_index == rdhuff_pkg::REG_HEIGHT) img_height <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        results <= results + 1;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected word %p", $time, out_word);
          errors <= errors + 1;
        end else begin
          e = expected_pixels.pop_front();
          if (out_word.pixel !== e.pixel || out_word.row_end !== e.row_end ||
              out_word.image_end !== e.image_end || out_word.status !== e.status) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_word);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) predict(in_word);
    end
  end

endmodule

>>> tb/row_delta_canonical_huffman_decoder_test.sv
`timescale 1ns / 1ps

module row_delta_canonical_huffman_decoder_test;

  logic                            clk, rst;
  logic                            in_valid, in_stall;
  rdhuff_pkg::in_word_t            in_word;
  logic                            out_valid, out_stall;
  rdhuff_pkg::out_word_t           out_word;
  logic                            cfg_valid, cfg_ready;
  logic [1:0]                      cfg_index;
  logic [rdhuff_pkg::DIM_BITS-1:0] cfg_data;
  int                              errors, waiting, results;

  logic                idle_on;
  logic                bit_stream[$];
  int                  tsym[$], tlen[$];
  logic [31:0]         tcode[$];
  int                  frames_sent, bits_sent;

  row_delta_canonical_huffman_decoder u_dut (
    .clk, .rst, .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  row_delta_canonical_huffman_decoder_checker u_chk (
    .clk, .rst, .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .waiting, .results
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) out_stall <= idle_on && $urandom_range(99) < 6;

  task automatic send_bit(logic b, logic fs);
    while (idle_on && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word.code_bit <= b;
    in_word.frame_start <= fs;
    do @(posedge clk); while (in_stall);
    bits_sent++;
  endtask

  task automatic push_bits(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) bit_stream.insert(bit_stream.size(), v[i]);
  endtask

  task automatic send_stream();
    for (int i = 0; i < bit_stream.size(); i++) send_bit(bit_stream[i], i == 0);
    bit_stream.delete();
    frames_sent++;
  endtask

  // pause the sender until every word is back, then let the pipe empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(rdhuff_pkg::reg_index_t idx, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_dims(logic [15:0] w, logic [15:0] h);
    drain();
    write_reg(rdhuff_pkg::REG_WIDTH, w);
    write_reg(rdhuff_pkg::REG_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // staircase or fixed-length table, codes assigned canonically
  task automatic make_table(int kind, int k);
    int n, stride;
    logic [31:0] code;
    int pl;
    tsym.delete(); tlen.delete(); tcode.delete();
    n = kind == 0 ? (1 << k) : k + 1;
    stride = 512 / n;
    for (int i = 0; i < n; i++) begin
      tsym.insert(tsym.size(), -256 + i * stride + $urandom_range(0, stride - 1));
      if (kind == 0) tlen.insert(tlen.size(), k);
      else tlen.insert(tlen.size(), i < k ? i + 1 : k);
    end
    code = 0; pl = 0;
    for (int i = 0; i < n; i++) begin
      if (tlen[i] > pl) code = code << (tlen[i] - pl);
      pl = tlen[i];
      tcode.insert(tcode.size(), code);
      code++;
    end
  endtask

  task automatic push_header();
    push_bits(tsym.size(), 9);
    foreach (tsym[i]) begin
      push_bits(tsym[i] & 511, 9);
      push_bits(tlen[i], 5);
    end
  endtask

  task automatic push_codes(int n, bit garble);
    int j;
    for (int p = 0; p < n; p++) begin
      j = $urandom_range(0, tsym.size() - 1);
      push_bits(tcode[j], tlen[j]);
      if (garble && $urandom_range(99) < 5) push_bits($urandom, $urandom_range(1, 32));
    end
  endtask

  initial begin
    int w, h, kind;
    idle_on = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = rdhuff_pkg::REG_WIDTH;
    cfg_data = '0;
    frames_sent = 0;
    bits_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_on = 1'b1;

    // symbol extremes, zero length, out of order entry, length 31
    set_dims(16'd3, 16'd2);
    push_bits(5, 9);
    push_bits(9'h100, 9); push_bits(1, 5);
    push_bits(9'h0FF, 9); push_bits(1, 5);
    push_bits(9'h000, 9); push_bits(0, 5);
    push_bits(9'h1FB, 9); push_bits(1, 5);
    push_bits(9'h007, 9); push_bits(31, 5);
    push_bits($urandom, 32); push_bits($urandom, 8);
    send_stream();

    // empty table: only no-match words
    push_bits(0, 9);
    push_bits($urandom, 32); push_bits($urandom, 32); push_bits($urandom, 10);
    send_stream();

    // largest entry count, cut short by the next frame
    set_dims(16'd4, 16'd4);
    push_bits(511, 9);
    for (int i = 0; i < 16; i++) begin
      push_bits(i - 256, 9);
      push_bits(9, 5);
    end
    send_stream();

    // restart partway through the header, then zero dimensions
    make_table(1, 4);
    push_header();
    bit_stream = bit_stream[0:20];
    send_stream();
    set_dims(16'd0, 16'd0);
    push_header();
    push_codes(3, 0);
    send_stream();

    // widest row and tallest column with a one-bit code
    make_table(0, 1);
    set_dims(16'hFFFF, 16'd1);
    push_header();
    push_codes(24, 0);
    send_stream();
    set_dims(16'd1, 16'hFFFF);
    push_header();
    push_codes(24, 0);
    send_stream();

    for (int f = 0; f < 9; f++) begin
      idle_on = !(f >= 3 && f < 6);
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 4);
      if (f % 3 == 0) set_dims(w[15:0], h[15:0]);
      kind = $urandom_range(0, 1);
      make_table(kind, kind == 0 ? $urandom_range(1, 3) : $urandom_range(2, 8));
      case ($urandom_range(0, 9))
        0: begin
          // broken table: a swapped pair or a zero length
          if (tsym.size() > 2 && $urandom_range(1)) begin
            int t;
            t = tsym[0]; tsym[0] = tsym[1]; tsym[1] = t;
            t = tlen[0]; tlen[0] = tlen[1]; tlen[1] = t;
          end else begin
            tlen[$urandom_range(0, tlen.size() - 1)] = 0;
          end
          push_header();
          for (int i = 0; i < 30; i++) bit_stream.insert(bit_stream.size(), $urandom_range(1));
        end
        1: begin
          push_header();
          for (int i = 0; i < 20; i++) bit_stream.insert(bit_stream.size(), $urandom_range(1));
        end
        default: begin
          push_header();
          push_codes(16, 1);
        end
      endcase
      send_stream();
    end
    idle_on = 1'b1;

    drain();
    $display("sent %0d frames, %0d coded bits; %0d words checked", frames_sent, bits_sent,
             results);
    $display("covered table rejects, no-match, empty and full tables, dimension extremes");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
